/* design/metp_pkg.sv */
// shared types, constants and helpers for the escape-time pixel block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package metp_pkg;

  // fixed field widths
  localparam int unsigned CoordW    = 32;  // width of c and z components
  localparam int unsigned IterW     = 12;  // iteration count / cap width
  localparam int unsigned ColorW    = 8;
  localparam int unsigned CfgW      = 32;  // widest config register
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned OutTdataW = 40;  // 12 + 3*8 = 36, padded to bytes
  localparam int unsigned SumW      = 66;  // headroom for sums before saturation
  localparam int unsigned ProdW     = 64;  // exact 32x32 product
  localparam int unsigned PalBits   = 3;   // palette of 8 entries

  // queue between front and engine
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // config register indexes
  localparam logic [CfgIdxW-1:0] RegXLeft   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegXStep   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegYTop    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegYStep   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxIter = 3'd4;

  // config reset values
  localparam logic signed [CoordW-1:0] XLeftRst   = -32'sd199990723;
  localparam logic signed [CoordW-1:0] XStepRst   = 32'sd448791;
  localparam logic signed [CoordW-1:0] YTopRst    = 32'sd87241523;
  localparam logic signed [CoordW-1:0] YStepRst   = 32'sd363506;
  localparam logic [IterW-1:0]         MaxIterRst = 12'd128;

  typedef struct packed {
    logic signed [CoordW-1:0] re;
    logic signed [CoordW-1:0] im;
  } cpoint_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x_left;
    logic signed [CoordW-1:0] x_step;
    logic signed [CoordW-1:0] y_top;
    logic signed [CoordW-1:0] y_step;
  } map_cfg_t;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } rgb_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_ADD,
    FS_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    ES_IDLE,
    ES_MUL,
    ES_EVAL,
    ES_DONE
  } eng_state_e;

  // clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [CoordW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'($signed({1'b0, {(CoordW-1){1'b1}}}));
    lo = SumW'($signed({1'b1, {(CoordW-1){1'b0}}}));
    if (v > hi) begin
      sat32 = {1'b0, {(CoordW-1){1'b1}}};
    end else if (v < lo) begin
      sat32 = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      sat32 = v[CoordW-1:0];
    end
  endfunction

  // eight-entry color palette
  function automatic rgb_t palette(input logic [PalBits-1:0] idx);
    rgb_t c;
    unique case (idx)
      3'd0: c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      3'd1: c = '{red: 8'd238, green: 8'd51,  blue: 8'd0};
      3'd2: c = '{red: 8'd9,   green: 8'd1,   blue: 8'd47};
      3'd3: c = '{red: 8'd4,   green: 8'd4,   blue: 8'd73};
      3'd4: c = '{red: 8'd0,   green: 8'd7,   blue: 8'd100};
      3'd5: c = '{red: 8'd12,  green: 8'd44,  blue: 8'd138};
      3'd6: c = '{red: 8'd24,  green: 8'd82,  blue: 8'd177};
      3'd7: c = '{red: 8'd57,  green: 8'd125, blue: 8'd209};
    endcase
    return c;
  endfunction

endpackage

/* design/metp_front.sv */
// front end: takes a pixel request and maps column/row to the point c
// depends on metp_pkg
`timescale 1ns / 1ps

module metp_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  metp_pkg::map_cfg_t        cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [COORD_BITS-1:0]     column_i,
  input  logic [COORD_BITS-1:0]     row_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output metp_pkg::cpoint_t         push_data_o
);
  import metp_pkg::*;

  localparam int unsigned MulW = COORD_BITS + CoordW + 1;

  front_state_e state_q, state_d;

  logic [COORD_BITS-1:0]    col_q, row_q;
  logic signed [MulW-1:0]   prod_x_q, prod_y_q;
  cpoint_t                  c_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: if (in_valid_i) state_d = FS_MUL;
      FS_MUL:  state_d = FS_ADD;
      FS_ADD:  state_d = FS_PUSH;
      FS_PUSH: if (push_ready_i) state_d = FS_IDLE;
      default: state_d = FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = (state_q == FS_IDLE);
    push_valid_o = (state_q == FS_PUSH);
  end

  assign push_data_o = c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == FS_IDLE && in_valid_i) begin
      col_q <= column_i;
      row_q <= row_i;
    end
    if (state_q == FS_MUL) begin
      prod_x_q <= $signed({1'b0, col_q}) * cfg_i.x_step;
      prod_y_q <= $signed({1'b0, row_q}) * cfg_i.y_step;
    end
    if (state_q == FS_ADD) begin
      c_q.re <= sat32(SumW'(prod_x_q) + SumW'(cfg_i.x_left));
      c_q.im <= sat32(SumW'(prod_y_q) - SumW'(cfg_i.y_top));
    end
  end

endmodule

/* design/metp_queue.sv */
// two-entry queue of points between front end and iteration engine
// depends on metp_pkg
`timescale 1ns / 1ps

module metp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  metp_pkg::cpoint_t   push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output metp_pkg::cpoint_t   pop_data_o
);
  import metp_pkg::*;

  cpoint_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   cnt_q;
  logic                   do_push, do_pop;

  assign push_ready_o = (cnt_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  function automatic logic [QueuePtrW-1:0] next_ptr(input logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + QueuePtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* design/metp_engine.sv */
// iteration engine: runs z = z*z + c, counts, and holds the result register
// depends on metp_pkg
`timescale 1ns / 1ps

module metp_engine #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [metp_pkg::IterW-1:0]    max_iter_i,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  metp_pkg::cpoint_t             pop_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [metp_pkg::IterW-1:0]    out_iter_o,
  output metp_pkg::rgb_t                out_rgb_o
);
  import metp_pkg::*;

  localparam logic signed [ProdW:0] Limit = (ProdW + 1)'(4) <<< FRAC_BITS;

  eng_state_e state_q, state_d;

  cpoint_t                   c_q;
  logic signed [CoordW-1:0]  zr_q, zi_q;
  logic signed [ProdW-1:0]   p_rr_q, p_ii_q, p_ri_q;
  logic [IterW-1:0]          count_q;
  logic                      out_valid_q;
  logic [IterW-1:0]          out_iter_q;
  rgb_t                      out_rgb_q;

  logic signed [ProdW-1:0]   xx, yy, xy2;
  logic signed [ProdW:0]     mag;
  logic                      escape;
  logic                      last_iter;
  logic                      load_out;

  // floored squares and doubled cross term from the product registers
  always_comb begin
    xx        = p_rr_q >>> FRAC_BITS;
    yy        = p_ii_q >>> FRAC_BITS;
    xy2       = p_ri_q >>> (FRAC_BITS - 1);
    mag       = (ProdW + 1)'(xx) + (ProdW + 1)'(yy);
    escape    = (mag >= Limit);
    last_iter = ((count_q + IterW'(1)) == max_iter_i);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ES_IDLE: begin
        if (pop_valid_i) state_d = (max_iter_i == '0) ? ES_DONE : ES_MUL;
      end
      ES_MUL:  state_d = ES_EVAL;
      ES_EVAL: state_d = (escape || last_iter) ? ES_DONE : ES_MUL;
      ES_DONE: if (!out_valid_q || out_ready_i) state_d = ES_IDLE;
      default: state_d = ES_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_ready_o = (state_q == ES_IDLE);
    load_out    = (state_q == ES_DONE) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;
  assign out_iter_o  = out_iter_q;
  assign out_rgb_o   = out_rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ES_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ES_IDLE: begin
        if (pop_valid_i) begin
          c_q     <= pop_data_i;
          zr_q    <= '0;
          zi_q    <= '0;
          count_q <= '0;
        end
      end
      ES_MUL: begin
        p_rr_q <= zr_q * zr_q;
        p_ii_q <= zi_q * zi_q;
        p_ri_q <= zr_q * zi_q;
      end
      ES_EVAL: begin
        if (!escape) begin
          count_q <= count_q + IterW'(1);
          zr_q    <= sat32(SumW'(xx) - SumW'(yy) + SumW'(c_q.re));
          zi_q    <= sat32(SumW'(xy2) + SumW'(c_q.im));
        end
      end
      ES_DONE: begin
        if (load_out) begin
          out_iter_q <= count_q;
          out_rgb_q  <= palette(count_q[PalBits-1:0]);
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/mandelbrot_escape_time_pixel.sv */
// escape-time pixel: a request passes the front end's multiply, add and push states and the
//   queue; the engine then loops until the point escapes or the count reaches the cap
// throughput is set by the iteration engine: a multiply state and an add/compare state per
//   iteration, plus an idle and a done state, and it takes a new point only when idle; the
//   front end steps through idle, multiply, add and push states for each pixel
// the front end, a two-entry queue and a result register decouple both stream sides
// reset (rst_ni low, asynchronous): streams empty, config back to its default view
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 28
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // config write port
  input  logic                                   cfg_we_i,
  input  logic [metp_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [metp_pkg::CfgW-1:0]              cfg_wdata_i,
  // pixel requests
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // column [COORD_BITS-1:0], row [2*COORD_BITS-1:COORD_BITS], zero pad
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // results
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // iterations [11:0], red [19:12], green [27:20], blue [35:28], zero pad
  output logic [metp_pkg::OutTdataW-1:0]         m_axis_tdata
);
  import metp_pkg::*;

  // config registers
  map_cfg_t          map_cfg_q;
  logic [IterW-1:0]  max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cfg_q.x_left <= XLeftRst;
      map_cfg_q.x_step <= XStepRst;
      map_cfg_q.y_top  <= YTopRst;
      map_cfg_q.y_step <= YStepRst;
      max_iter_q       <= MaxIterRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegXLeft:   map_cfg_q.x_left <= cfg_wdata_i;
        RegXStep:   map_cfg_q.x_step <= cfg_wdata_i;
        RegYTop:    map_cfg_q.y_top  <= cfg_wdata_i;
        RegYStep:   map_cfg_q.y_step <= cfg_wdata_i;
        RegMaxIter: max_iter_q       <= cfg_wdata_i[IterW-1:0];
        default:    ;  // unknown index, write dropped
      endcase
    end
  end

  // front end -> queue -> engine
  logic     push_valid, push_ready;
  cpoint_t  push_data;
  logic     pop_valid, pop_ready;
  cpoint_t  pop_data;

  logic [IterW-1:0]  res_iter;
  rgb_t              res_rgb;

  metp_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (map_cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .column_i     (s_axis_tdata[COORD_BITS-1:0]),
    .row_i        (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // lets the front end map the next pixel while the engine iterates
  metp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // engine holds its finished result in a register until the sink takes it
  metp_engine #(
    .FRAC_BITS (FRAC_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_iter_i  (max_iter_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_iter_o  (res_iter),
    .out_rgb_o   (res_rgb)
  );

  // pack result, lowest field first
  assign m_axis_tdata = {
    (OutTdataW - IterW - 3*ColorW)'(0),
    res_rgb.blue,
    res_rgb.green,
    res_rgb.red,
    res_iter
  };

endmodule
